FILE: src/gcsp_pkg.sv
`default_nettype none

package gcsp_pkg;

   localparam int COORD_BITS = 13;
   localparam int CODE_BITS = 21;
   localparam int DEF_TABLE_ENTRIES = 256;
   localparam int CSR_ADDR_BITS = 2;
   localparam logic [COORD_BITS-1:0] ATLAS_RESET = COORD_BITS'(1024);

   typedef enum logic [2:0] {
      ST_HIT         = 3'd0,
      ST_PLACED      = 3'd1,
      ST_RENDER_FAIL = 3'd2,
      ST_TOO_LARGE   = 3'd3,
      ST_ATLAS_FULL  = 3'd4,
      ST_TABLE_FULL  = 3'd5
   } status_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_ATLAS_WIDTH  = 2'd0,
      REG_ATLAS_HEIGHT = 2'd1
   } reg_index_type;

   typedef logic [COORD_BITS-1:0] coord_type;

   // packed with x in the lowest bits
   typedef struct packed {
      coord_type h;
      coord_type w;
      coord_type y;
      coord_type x;
   } rect_type;

   localparam int RECT_BITS = $bits(rect_type);
   localparam int ENTRY_BITS = RECT_BITS + CODE_BITS;

   typedef struct packed {
      coord_type glyph_width;
      coord_type glyph_height;
      logic      render_ok;
      coord_type atlas_width;
      coord_type atlas_height;
      logic      table_full;
   } place_req_type;

   typedef struct packed {
      status_type status;
      rect_type   rect;
      logic       store;
   } place_res_type;

endpackage

`default_nettype wire

FILE: src/gcsp_ram.sv
`default_nettype none

module gcsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: src/gcsp_placer.sv
`default_nettype none

module gcsp_placer
   import gcsp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          apply,
   input  wire place_req_type req,
   output place_res_type      res
);

   coord_type cursor_x_ff, cursor_x_in;
   coord_type cursor_y_ff, cursor_y_in;
   coord_type row_height_ff, row_height_in;

   logic [COORD_BITS:0] sum_x;
   logic [COORD_BITS:0] sum_row;
   logic [COORD_BITS:0] sum_y;
   logic                wrap;
   logic                too_large;
   logic                full;
   coord_type           cx_w, cy_w, rh_w;
   coord_type           cx_new, rh_new;

   always_comb begin
      too_large = (req.glyph_width > req.atlas_width) || (req.glyph_height > req.atlas_height);
      sum_x = {1'b0, cursor_x_ff} + {1'b0, req.glyph_width};
      wrap = sum_x > {1'b0, req.atlas_width};
      sum_row = {1'b0, cursor_y_ff} + {1'b0, row_height_ff};
      if (wrap) begin
         cx_w = '0;
         cy_w = sum_row[COORD_BITS] ? '1 : sum_row[COORD_BITS-1:0];
         rh_w = '0;
      end else begin
         cx_w = cursor_x_ff;
         cy_w = cursor_y_ff;
         rh_w = row_height_ff;
      end
      sum_y = {1'b0, cy_w} + {1'b0, req.glyph_height};
      full = sum_y > {1'b0, req.atlas_height};
      cx_new = wrap ? req.glyph_width : sum_x[COORD_BITS-1:0];
      rh_new = (req.glyph_height > rh_w) ? req.glyph_height : rh_w;

      res.status = ST_PLACED;
      res.rect = '0;
      res.store = 1'b0;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      row_height_in = row_height_ff;
      if (!req.render_ok) begin
         res.status = ST_RENDER_FAIL;
      end else if (too_large) begin
         res.status = ST_TOO_LARGE;
      end else if (req.table_full) begin
         res.status = ST_TABLE_FULL;
      end else if (full) begin
         res.status = ST_ATLAS_FULL;
         cursor_x_in = cx_w;
         cursor_y_in = cy_w;
         row_height_in = rh_w;
      end else begin
         res.store = 1'b1;
         res.rect.x = cx_w;
         res.rect.y = cy_w;
         res.rect.w = req.glyph_width;
         res.rect.h = req.glyph_height;
         cursor_x_in = cx_new;
         cursor_y_in = cy_w;
         row_height_in = rh_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         row_height_ff <= '0;
      end else if (apply) begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         row_height_ff <= row_height_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/glyph_cache_shelf_packer.sv
`default_nettype none

// Channel  | Dir | Handshake             | Payload
// req      | in  | req_tvalid/req_tready | tdata: codepoint, glyph_width, glyph_height
//          |     |                       | tuser: render_ok
// rsp      | out | rsp_tvalid/rsp_tready | tdata: rect_x, rect_y, rect_w, rect_h
//          |     |                       | tuser: status
// csr      | in  | csr_wen               | csr_addr, csr_wdata
//
// One item at a time: the time from accept to rsp_tvalid is set by the linear scan of the
// glyph table, one entry a cycle, which ends at a hit or after the last entry on a miss.
// Reset clears the entry count and cursor; atlas size returns to 1024 x 1024.
// A held result in the output register does not block the next item; only the
// transfer of a new result waits on rsp_tready.

module glyph_cache_shelf_packer
   import gcsp_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // codepoint[20:0], glyph_width[33:21], glyph_height[46:34], zero[47]
   input  wire logic [47:0]              req_tdata,
   // render_ok[0]
   input  wire logic                     req_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // rect_x[12:0], rect_y[25:13], rect_w[38:26], rect_h[51:39], zero[55:52]
   output logic      [55:0]              rsp_tdata,
   // status[2:0]
   output logic      [2:0]               rsp_tuser,
   input  wire logic                     csr_wen,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [COORD_BITS-1:0]    csr_wdata
);

   localparam int IDXW = $clog2(TABLE_ENTRIES);
   localparam int CNTW = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_PLACE = 4'b0100,
      S_OUT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   coord_type atlas_width_ff, atlas_height_ff;

   logic [CODE_BITS-1:0] req_code_ff;
   coord_type            req_w_ff, req_h_ff;
   logic                 req_ok_ff;

   logic [CNTW-1:0] count_ff, count_in;
   logic [CNTW-1:0] rd_idx_ff, rd_idx_in;
   logic            issue_ff, issue_in;

   status_type res_status_ff, res_status_in;
   rect_type   res_rect_ff, res_rect_in;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   rect_type   rsp_rect_ff;

   logic                  accept;
   logic                  hit;
   logic                  rsp_load;
   logic                  ram_we;
   logic [ENTRY_BITS-1:0] ram_rdata;
   place_req_type         preq;
   place_res_type         pres;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign hit = issue_ff && (ram_rdata[CODE_BITS-1:0] == req_code_ff);
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign ram_we = (state_ff == S_PLACE) && pres.store;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {4'b0, rsp_rect_ff};
   assign rsp_tuser = rsp_status_ff;

   always_comb begin
      preq.glyph_width = req_w_ff;
      preq.glyph_height = req_h_ff;
      preq.render_ok = req_ok_ff;
      preq.atlas_width = atlas_width_ff;
      preq.atlas_height = atlas_height_ff;
      preq.table_full = (count_ff == CNTW'(TABLE_ENTRIES));
   end

   gcsp_placer u_placer (
      .clock (clock),
      .reset (reset),
      .apply (state_ff == S_PLACE),
      .req   (preq),
      .res   (pres)
   );

   gcsp_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDXW-1:0]),
      .wr_data ({pres.rect, req_code_ff}),
      .rd_addr (rd_idx_ff[IDXW-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      rd_idx_in = rd_idx_ff;
      issue_in = 1'b0;
      count_in = count_ff;
      res_status_in = res_status_ff;
      res_rect_in = res_rect_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rd_idx_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit) begin
               res_status_in = ST_HIT;
               res_rect_in = rect_type'(ram_rdata[ENTRY_BITS-1:CODE_BITS]);
               state_in = S_OUT;
            end else if (rd_idx_ff == count_ff) begin
               state_in = S_PLACE;
            end else begin
               issue_in = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         S_PLACE: begin
            res_status_in = pres.status;
            res_rect_in = pres.rect;
            if (pres.store) begin
               count_in = count_ff + 1'b1;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         issue_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         atlas_width_ff <= ATLAS_RESET;
         atlas_height_ff <= ATLAS_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            unique case (csr_addr)
               REG_ATLAS_WIDTH:  atlas_width_ff <= csr_wdata;
               REG_ATLAS_HEIGHT: atlas_height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      res_status_ff <= res_status_in;
      res_rect_ff <= res_rect_in;
      if (accept) begin
         req_code_ff <= req_tdata[CODE_BITS-1:0];
         req_w_ff <= req_tdata[CODE_BITS+COORD_BITS-1:CODE_BITS];
         req_h_ff <= req_tdata[CODE_BITS+2*COORD_BITS-1:CODE_BITS+COORD_BITS];
         req_ok_ff <= req_tuser;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_rect_ff <= res_rect_ff;
      end
   end

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
   import gcsp_pkg::*;

   localparam int RUN_LIMIT = 2_000_000;
   localparam int SETTLE_CYCLES = DEF_TABLE_ENTRIES + 40;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 219;
   localparam int COORD_MAX = (1 << COORD_BITS) - 1;
   localparam int CODE_MAX = (1 << CODE_BITS) - 1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_UNMAPPED = 2'd3;

   typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_type;

   typedef struct packed {
      status_type status;
      rect_type   rect;
   } glyph_answer_type;

   class atlas_scoreboard;
      coord_type atlas_w;
      coord_type atlas_h;
      rect_type placed[bit [CODE_BITS-1:0]];
      int unsigned cur_x;
      int unsigned cur_y;
      int unsigned row_h;
      glyph_answer_type answers[$];
      int errors;

      function new();
         atlas_w = ATLAS_RESET;
         atlas_h = ATLAS_RESET;
         cur_x = 0;
         cur_y = 0;
         row_h = 0;
         errors = 0;
      endfunction

      function void set_atlas_reg(logic [CSR_ADDR_BITS-1:0] idx, coord_type val);
         if (idx == REG_ATLAS_WIDTH)
            atlas_w = val;
         else if (idx == REG_ATLAS_HEIGHT)
            atlas_h = val;
      endfunction

      // lookup first, then render, size, table and shelf placement
      function void note_request(bit [CODE_BITS-1:0] code, coord_type gw, coord_type gh,
                                 logic ok);
         glyph_answer_type ans;
         int unsigned next_y;
         ans.status = ST_HIT;
         ans.rect = '0;
         if (placed.exists(code)) begin
            ans.rect = placed[code];
         end else if (!ok) begin
            ans.status = ST_RENDER_FAIL;
         end else if (gw > atlas_w || gh > atlas_h) begin
            ans.status = ST_TOO_LARGE;
         end else if (placed.num() >= DEF_TABLE_ENTRIES) begin
            ans.status = ST_TABLE_FULL;
         end else begin
            if (cur_x + gw > atlas_w) begin
               cur_x = 0;
               next_y = cur_y + row_h;
               cur_y = (next_y > COORD_MAX) ? COORD_MAX : next_y;
               row_h = 0;
            end
            if (cur_y + gh > atlas_h) begin
               ans.status = ST_ATLAS_FULL;
            end else begin
               ans.status = ST_PLACED;
               ans.rect.x = coord_type'(cur_x);
               ans.rect.y = coord_type'(cur_y);
               ans.rect.w = gw;
               ans.rect.h = gh;
               placed[code] = ans.rect;
               cur_x = (cur_x + gw) & COORD_MAX;
               if (gh > row_h)
                  row_h = 32'(gh);
            end
         end
         answers.push_back(ans);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(logic [2:0] st, logic [55:0] data);
         glyph_answer_type want;
         if (answers.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual status %0d data %h",
                     $time, st, data);
            return;
         end
         want = answers.pop_front();
         compare_field("status", 16'(want.status), 16'(st));
         compare_field("rect_x", 16'(want.rect.x), 16'(data[12:0]));
         compare_field("rect_y", 16'(want.rect.y), 16'(data[25:13]));
         compare_field("rect_w", 16'(want.rect.w), 16'(data[38:26]));
         compare_field("rect_h", 16'(want.rect.h), 16'(data[51:39]));
         compare_field("pad", 16'd0, 16'(data[55:52]));
      endfunction

      function int pending();
         return answers.size();
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic csr_wen = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   coord_type csr_wdata = '0;

   pace_type pace = PACE_FREE;
   atlas_scoreboard board;
   bit [CODE_BITS-1:0] used_codes[$];

   glyph_cache_shelf_packer #(
      .TABLE_ENTRIES(DEF_TABLE_ENTRIES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (RUN_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready <= $urandom_range(0, 99) >=
                    ((pace == PACE_RECEIVER) ? 52 : (pace == PACE_BOTH) ? 26 : 0);
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_request(req_tdata[20:0], req_tdata[33:21], req_tdata[46:34], req_tuser);
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tuser, rsp_tdata);
   end

   task automatic send_glyph(input bit [CODE_BITS-1:0] code, input coord_type gw,
                             input coord_type gh, input logic ok);
      int gap;
      gap = (pace == PACE_SENDER) ? 52 : (pace == PACE_BOTH) ? 26 : 0;
      @(negedge clock);
      while ($urandom_range(0, 99) < gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, gh, gw, code};
      req_tuser <= ok;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      used_codes.push_back(code);
   endtask

   task automatic program_reg(input logic [CSR_ADDR_BITS-1:0] idx, input coord_type val);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen <= 1'b0;
      board.set_atlas_reg(idx, val);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   initial begin
      bit [CODE_BITS-1:0] code;
      coord_type gw;
      coord_type gh;
      coord_type width_set[PHASES];
      coord_type height_set[PHASES];
      int pick;
      board = new();
      width_set = '{13'd4096, 13'd256, 13'd1, 13'd8191, 13'd0, 13'd0, 13'd4096, 13'd2048};
      height_set = '{13'd4096, 13'd8191, 13'd1, 13'd8191, 13'd0, 13'd0, 13'd1, 13'd8191};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset atlas is 1024 x 1024
      send_glyph(21'h000000, 13'd0, 13'd0, 1'b1);
      send_glyph(21'h000000, 13'd5, 13'd5, 1'b0);
      send_glyph(21'h1FFFFF, 13'd8191, 13'd1, 1'b1);
      send_glyph(21'h1FFFFF, 13'd1, 13'd8191, 1'b1);
      send_glyph(21'h1FFFFF, 13'd1025, 13'd0, 1'b1);
      send_glyph(21'h1FFFFF, 13'd8191, 13'd8191, 1'b0);
      send_glyph(21'h1FFFFF, 13'd1024, 13'd16, 1'b1);
      send_glyph(21'h000005, 13'd1, 13'd8, 1'b1);
      // wraps, then does not fit below
      send_glyph(21'h100000, 13'd1024, 13'd1008, 1'b1);
      send_glyph(21'h100000, 13'd1024, 13'd1008, 1'b0);
      send_glyph(21'h100000, 13'd1024, 13'd1000, 1'b1);
      send_glyph(21'h0AAAAA, 13'd0, 13'd0, 1'b1);
      send_glyph(21'h155555, 13'd1, 13'd1, 1'b1);
      send_glyph(21'h155555, 13'd0, 13'd0, 1'b1);
      send_glyph(21'h1FFFFF, 13'd0, 13'd0, 1'b1);
      send_glyph(21'h000005, 13'd8191, 13'd8191, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         pace = pace_type'(p % 4);
         if (p == 5) begin
            width_set[p] = coord_type'($urandom_range(1, 4096));
            height_set[p] = coord_type'($urandom_range(1, 4096));
            program_reg(REG_UNMAPPED, coord_type'($urandom_range(0, COORD_MAX)));
         end
         program_reg(REG_ATLAS_WIDTH, width_set[p]);
         program_reg(REG_ATLAS_HEIGHT, height_set[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (used_codes.size() != 0 && $urandom_range(0, 99) < 55)
               code = used_codes[$urandom_range(0, used_codes.size() - 1)];
            else
               code = CODE_BITS'($urandom_range(0, CODE_MAX));
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               gw = coord_type'($urandom_range(0, 63));
               gh = coord_type'($urandom_range(0, 63));
            end else if (pick < 95) begin
               gw = coord_type'($urandom_range(0, board.atlas_w));
               gh = coord_type'($urandom_range(0, board.atlas_h));
            end else begin
               gw = coord_type'($urandom_range(0, COORD_MAX));
               gh = coord_type'($urandom_range(0, COORD_MAX));
            end
            send_glyph(code, gw, gh, $urandom_range(0, 99) >= 8);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
